>>> hdl/pcqbuf_pkg.sv
// ----------------------------------------------------------------------------
// pcqbuf_pkg
// Shared constants, codes and controller/datapath bundles for the per-class
// queue bank with urgent insertion at the front.
// ----------------------------------------------------------------------------
package pcqbuf_pkg;

   // Bank geometry
   localparam int NUM_QUEUES  = 32;
   localparam int QUEUE_DEPTH = 8;
   localparam int TAG_WIDTH   = 16;

   // Fixed port widths
   localparam int OP_W        = 1;
   localparam int QIDX_W      = 5;
   localparam int REQ_TAG_W   = 16;
   localparam int RSP_TAG_W   = 16;
   localparam int RSP_CNT_W   = 4;
   localparam int STATUS_W    = 2;

   // Derived widths
   localparam int SLOT_COUNT  = NUM_QUEUES * QUEUE_DEPTH;
   localparam int ADDR_W      = $clog2(SLOT_COUNT);
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int QSEL_W      = $clog2(NUM_QUEUES);
   localparam int ENTRY_W     = TAG_WIDTH + 1;

   typedef enum logic [OP_W-1:0] {
      OP_ADD = 1'b0,
      OP_POP = 1'b1
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_ADDED  = 2'd0,
      ST_FULL   = 2'd1,
      ST_POPPED = 2'd2,
      ST_EMPTY  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'd0,
      S_EXEC = 2'd1,
      S_READ = 2'd2
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;        // capture the request fields
      logic exec;        // update queue state and issue the memory access
      logic finish;      // present a result that needs no memory data
      logic finish_pop;  // present a popped entry from the memory read data
   } ctrl_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic pop_read;    // current item pops a real entry
   } dp_stat_type;

endpackage

>>> hdl/pcqbuf_ram.sv
// ----------------------------------------------------------------------------
// pcqbuf_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered.
// ----------------------------------------------------------------------------
module pcqbuf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/pcqbuf_dpath.sv
// ----------------------------------------------------------------------------
// pcqbuf_dpath
// Datapath: request capture, per-queue fill counts and head pointers, the
// entry memory (each queue a circular buffer) and the result registers.
// ----------------------------------------------------------------------------
module pcqbuf_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  pcqbuf_pkg::ctrl_cmd_type            cmd,
   output pcqbuf_pkg::dp_stat_type             stat,
   input  logic [pcqbuf_pkg::OP_W-1:0]         req_opcode,
   input  logic [pcqbuf_pkg::QIDX_W-1:0]       req_queue_index,
   input  logic [pcqbuf_pkg::REQ_TAG_W-1:0]    req_entry_tag,
   input  logic                                req_urgent,
   output logic                                rsp_strobe,
   output logic [pcqbuf_pkg::STATUS_W-1:0]     rsp_status,
   output logic [pcqbuf_pkg::RSP_TAG_W-1:0]    rsp_head_tag,
   output logic                                rsp_head_urgent,
   output logic [pcqbuf_pkg::RSP_CNT_W-1:0]    rsp_queue_count
);
   import pcqbuf_pkg::*;

   // Captured request
   op_type                 op_ff;
   logic [QIDX_W-1:0]      q_ff;
   logic [TAG_WIDTH-1:0]   tag_ff;
   logic                   urg_ff;

   // Per-queue state
   logic [CNT_W-1:0]       count_ff [NUM_QUEUES];
   logic [PTR_W-1:0]       head_ff  [NUM_QUEUES];

   // Result registers
   logic                   strobe_ff;
   status_type             status_ff;
   logic [RSP_TAG_W-1:0]   head_tag_ff;
   logic                   head_urg_ff;
   logic [RSP_CNT_W-1:0]   count_out_ff;

   logic                   in_range;
   logic [QSEL_W-1:0]      sel;
   logic [CNT_W-1:0]       cur_cnt;
   logic [PTR_W-1:0]       cur_head;
   logic                   is_full;
   logic                   is_empty;
   logic                   do_add;
   logic                   do_pop;
   logic [PTR_W-1:0]       head_dec;
   logic [PTR_W-1:0]       head_inc;
   logic [PTR_W:0]         tail_sum;
   logic [PTR_W-1:0]       tail_ptr;
   logic [PTR_W-1:0]       slot;
   logic [ADDR_W-1:0]      mem_addr;
   logic [CNT_W-1:0]       new_cnt;
   status_type             new_status;
   logic [ENTRY_W-1:0]     rd_entry;

   // Capture the request at acceptance
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= op_type'(req_opcode);
         q_ff   <= req_queue_index;
         tag_ff <= TAG_WIDTH'(req_entry_tag);
         urg_ff <= req_urgent;
      end
   end

   // Look up the addressed queue
   assign in_range = 32'(q_ff) < NUM_QUEUES;
   assign sel      = QSEL_W'(q_ff);
   assign cur_cnt  = in_range ? count_ff[sel] : '0;
   assign cur_head = in_range ? head_ff[sel]  : '0;
   assign is_full  = cur_cnt == CNT_W'(QUEUE_DEPTH);
   assign is_empty = cur_cnt == '0;
   assign do_add   = in_range && (op_ff == OP_ADD) && !is_full;
   assign do_pop   = in_range && (op_ff == OP_POP) && !is_empty;

   assign stat.pop_read = do_pop;

   // Circular pointer arithmetic
   always_comb begin
      head_dec = (cur_head == '0) ? PTR_W'(QUEUE_DEPTH - 1) : cur_head - PTR_W'(1);
      head_inc = (cur_head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : cur_head + PTR_W'(1);
      tail_sum = {1'b0, cur_head} + (PTR_W + 1)'(cur_cnt);
      tail_ptr = (tail_sum >= (PTR_W + 1)'(QUEUE_DEPTH))
               ? PTR_W'(tail_sum - (PTR_W + 1)'(QUEUE_DEPTH))
               : PTR_W'(tail_sum);
      if (op_ff == OP_POP) begin
         slot = cur_head;
      end else if (urg_ff) begin
         slot = head_dec;
      end else begin
         slot = tail_ptr;
      end
      mem_addr = ADDR_W'(sel) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(slot);
   end

   // Result status and count after the operation
   always_comb begin
      new_cnt = cur_cnt;
      if (do_add) begin
         new_cnt = cur_cnt + CNT_W'(1);
      end else if (do_pop) begin
         new_cnt = cur_cnt - CNT_W'(1);
      end
      if (op_ff == OP_ADD) begin
         new_status = do_add ? ST_ADDED : ST_FULL;
      end else begin
         new_status = do_pop ? ST_POPPED : ST_EMPTY;
      end
   end

   // Advance count and head pointer of the addressed queue
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_QUEUES; i++) begin
            count_ff[i] <= '0;
            head_ff[i]  <= '0;
         end
      end else if (cmd.exec && (do_add || do_pop)) begin
         count_ff[sel] <= new_cnt;
         if (do_pop) begin
            head_ff[sel] <= head_inc;
         end else if (urg_ff) begin
            head_ff[sel] <= head_dec;
         end
      end
   end

   // Entry memory: urgent flag above the tag
   pcqbuf_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOT_COUNT)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (cmd.exec && do_add),
      .wr_addr (mem_addr),
      .wr_data ({urg_ff, tag_ff}),
      .rd_en   (cmd.exec && do_pop),
      .rd_addr (mem_addr),
      .rd_data (rd_entry)
   );

   // Result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.finish || cmd.finish_pop;
      end
   end

   // Result payload: status and count at execute, entry from the read data
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         status_ff    <= new_status;
         count_out_ff <= RSP_CNT_W'(new_cnt);
         head_tag_ff  <= '0;
         head_urg_ff  <= 1'b0;
      end else if (cmd.finish_pop) begin
         head_tag_ff  <= RSP_TAG_W'(rd_entry[TAG_WIDTH-1:0]);
         head_urg_ff  <= rd_entry[ENTRY_W-1];
      end
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_status      = status_ff;
   assign rsp_head_tag    = head_tag_ff;
   assign rsp_head_urgent = head_urg_ff;
   assign rsp_queue_count = count_out_ff;

endmodule

>>> hdl/pcqbuf_ctrl.sv
// ----------------------------------------------------------------------------
// pcqbuf_ctrl
// Controller: sequences accept, execute and, for a pop that finds an entry,
// the memory read state.
// ----------------------------------------------------------------------------
module pcqbuf_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  pcqbuf_pkg::dp_stat_type   stat,
   output pcqbuf_pkg::ctrl_cmd_type  cmd
);
   import pcqbuf_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      case (state_ff)
         S_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            if (stat.pop_read) begin
               state_in = S_READ;
            end else begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_READ: begin
            cmd.finish_pop = 1'b1;
            state_in       = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

>>> hdl/per_class_queue_bank_urgent_front_core.sv
// ----------------------------------------------------------------------------
// per_class_queue_bank_urgent_front_core
// Bank of bounded per-class queues with add-at-tail, urgent add-at-head and
// pop-head operations, one status result per operation.
// ----------------------------------------------------------------------------
// An operation is taken when start is high and busy is low. An add, a refused
// add, an empty pop or any operation on a queue beyond the bank passes through
// accept and execute; a pop that returns an entry adds a read state for the
// registered read of the entry memory. The result appears on the rsp_ ports
// for exactly one cycle with rsp_strobe high, in the first cycle busy is low
// again; the receiver cannot stall it, so it must take every result as it
// comes. Each queue is a circular buffer in one shared entry memory; of the
// queue state, only the fill counts and head pointers are cleared by reset.
module per_class_queue_bank_urgent_front_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [pcqbuf_pkg::OP_W-1:0]         req_opcode,
   input  logic [pcqbuf_pkg::QIDX_W-1:0]       req_queue_index,
   input  logic [pcqbuf_pkg::REQ_TAG_W-1:0]    req_entry_tag,
   input  logic                                req_urgent,
   output logic                                rsp_strobe,
   output logic [pcqbuf_pkg::STATUS_W-1:0]     rsp_status,
   output logic [pcqbuf_pkg::RSP_TAG_W-1:0]    rsp_head_tag,
   output logic                                rsp_head_urgent,
   output logic [pcqbuf_pkg::RSP_CNT_W-1:0]    rsp_queue_count
);
   import pcqbuf_pkg::*;

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   pcqbuf_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   pcqbuf_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_opcode      (req_opcode),
      .req_queue_index (req_queue_index),
      .req_entry_tag   (req_entry_tag),
      .req_urgent      (req_urgent),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_head_tag    (rsp_head_tag),
      .rsp_head_urgent (rsp_head_urgent),
      .rsp_queue_count (rsp_queue_count)
   );

   // A result only shows once the block is free again
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while busy");

   // An accepted item keeps the block busy in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_strobe))
      else $error("accepted item did not occupy the block");

   // Only a pop carries entry data
   a_no_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != ST_POPPED)) |->
         ((rsp_head_tag == '0) && (rsp_head_urgent == 1'b0)))
      else $error("entry data on a result that is not a pop");

   // A successful add leaves at least one entry
   a_add_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status == ST_ADDED)) |-> (rsp_queue_count != '0))
      else $error("add reported an empty queue");

   // An empty pop reports zero entries
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status == ST_EMPTY)) |-> (rsp_queue_count == '0))
      else $error("empty pop reported entries");

endmodule

>>> sim/per_class_queue_bank_urgent_front_core_test.sv
// ----------------------------------------------------------------------------
// per_class_queue_bank_urgent_front_core_test
// Self-checking bench for the per-class queue bank. A short table of directed
// items covers empty pops, the index and tag extremes, urgent and regular
// adds, a full queue and a full drain. Random traffic follows, clustered on a
// few hot queues per phase so that queues fill, overflow and drain. Every
// response is checked field by field against its table row or an in-bench model of the bank.
// ----------------------------------------------------------------------------
module per_class_queue_bank_urgent_front_core_test;
   import pcqbuf_pkg::*;

   localparam int RANDOM_ITEMS  = 1550;
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_LIMIT   = 1000;

   typedef struct packed {
      op_type                  op;
      logic [QIDX_W-1:0]       qidx;
      logic [REQ_TAG_W-1:0]    tag;
      logic                    urgent;
   } cmd_type;

   typedef struct packed {
      status_type              status;
      logic [RSP_TAG_W-1:0]    head_tag;
      logic                    head_urgent;
      logic [RSP_CNT_W-1:0]    count;
   } outcome_type;

   typedef struct {
      cmd_type     cmd;
      bit          typed;
      outcome_type want;
   } plan_row_type;

   // Traffic shape of one random phase
   typedef enum int {
      MIX_FILL,
      MIX_DRAIN,
      MIX_EVEN
   } traffic_mix_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic [OP_W-1:0]         req_opcode = '0;
   logic [QIDX_W-1:0]       req_queue_index = '0;
   logic [REQ_TAG_W-1:0]    req_entry_tag = '0;
   logic                    req_urgent = 1'b0;
   logic                    rsp_strobe;
   logic [STATUS_W-1:0]     rsp_status;
   logic [RSP_TAG_W-1:0]    rsp_head_tag;
   logic                    rsp_head_urgent;
   logic [RSP_CNT_W-1:0]    rsp_queue_count;

   // Model of the bank: entries per queue, head at slot 0
   logic [TAG_WIDTH-1:0]    slot_tag    [NUM_QUEUES][QUEUE_DEPTH];
   logic                    slot_urgent [NUM_QUEUES][QUEUE_DEPTH];
   int                      fill        [NUM_QUEUES];

   outcome_type             awaited_results[$];
   plan_row_type            directed_plan[$];
   int                      status_tally[4];
   int                      burst_left = 0;
   int                      fail_count = 0;

   per_class_queue_bank_urgent_front_core u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_opcode      (req_opcode),
      .req_queue_index (req_queue_index),
      .req_entry_tag   (req_entry_tag),
      .req_urgent      (req_urgent),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_head_tag    (rsp_head_tag),
      .rsp_head_urgent (rsp_head_urgent),
      .rsp_queue_count (rsp_queue_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Apply one operation to the model bank and return its response
   function automatic outcome_type predict_queue_op(input cmd_type c);
      outcome_type r;
      int          n;
      int          i;
      r = '0;
      if (int'(c.qidx) >= NUM_QUEUES) begin
         r.status = (c.op == OP_POP) ? ST_EMPTY : ST_FULL;
         return r;
      end
      n = fill[c.qidx];
      if (c.op == OP_ADD) begin
         if (n >= QUEUE_DEPTH) begin
            r.status = ST_FULL;
            r.count  = RSP_CNT_W'(n);
            return r;
         end
         if (c.urgent) begin
            // shift back by one and put the new entry at the head
            for (i = n; i > 0; i--) begin
               slot_tag[c.qidx][i]    = slot_tag[c.qidx][i-1];
               slot_urgent[c.qidx][i] = slot_urgent[c.qidx][i-1];
            end
            slot_tag[c.qidx][0]    = TAG_WIDTH'(c.tag);
            slot_urgent[c.qidx][0] = 1'b1;
         end else begin
            slot_tag[c.qidx][n]    = TAG_WIDTH'(c.tag);
            slot_urgent[c.qidx][n] = 1'b0;
         end
         n++;
         fill[c.qidx] = n;
         r.status = ST_ADDED;
         r.count  = RSP_CNT_W'(n);
         return r;
      end
      if (n == 0) begin
         r.status = ST_EMPTY;
         return r;
      end
      r.status      = ST_POPPED;
      r.head_tag    = RSP_TAG_W'(slot_tag[c.qidx][0]);
      r.head_urgent = slot_urgent[c.qidx][0];
      // advance the rest of the queue toward the head
      for (i = 1; i < n; i++) begin
         slot_tag[c.qidx][i-1]    = slot_tag[c.qidx][i];
         slot_urgent[c.qidx][i-1] = slot_urgent[c.qidx][i];
      end
      n--;
      fill[c.qidx] = n;
      r.count = RSP_CNT_W'(n);
      return r;
   endfunction

   // Append one row to the directed table
   function automatic void plan(input op_type op, input int q, input logic [15:0] tag,
                                input logic urg, input bit typed, input status_type st,
                                input logic [15:0] htag, input logic hurg, input int cnt);
      plan_row_type row;
      row.cmd.op           = op;
      row.cmd.qidx         = QIDX_W'(q);
      row.cmd.tag          = tag;
      row.cmd.urgent       = urg;
      row.typed            = typed;
      row.want.status      = st;
      row.want.head_tag    = htag;
      row.want.head_urgent = hurg;
      row.want.count       = RSP_CNT_W'(cnt);
      directed_plan.push_back(row);
   endfunction

   // Offer one item, hold it until taken, then pace the sender in bursts
   task automatic issue(input cmd_type c, input bit typed, input outcome_type want);
      outcome_type predicted;
      int          gap;
      start           <= 1'b1;
      req_opcode      <= c.op;
      req_queue_index <= c.qidx;
      req_entry_tag   <= c.tag;
      req_urgent      <= c.urgent;
      do @(posedge clock); while (busy !== 1'b0);
      predicted = predict_queue_op(c);
      awaited_results.push_back(typed ? want : predicted);
      status_tally[predicted.status]++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 23);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
         if (gap > 0) begin
            // drop start and scramble the payload while idle
            start           <= 1'b0;
            req_opcode      <= OP_W'($urandom);
            req_queue_index <= QIDX_W'($urandom);
            req_entry_tag   <= REQ_TAG_W'($urandom);
            req_urgent      <= 1'($urandom);
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Check each response against the oldest expectation
   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (awaited_results.size() == 0) begin
            $error("unexpected response: status %0d count %0d", rsp_status, rsp_queue_count);
            fail_count++;
         end else begin
            want = awaited_results.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               fail_count++;
            end
            if (rsp_head_tag !== want.head_tag) begin
               $error("head_tag: expected %h, got %h", want.head_tag, rsp_head_tag);
               fail_count++;
            end
            if (rsp_head_urgent !== want.head_urgent) begin
               $error("head_urgent: expected %0d, got %0d", want.head_urgent,
                      rsp_head_urgent);
               fail_count++;
            end
            if (rsp_queue_count !== want.count) begin
               $error("queue_count: expected %0d, got %0d", want.count, rsp_queue_count);
               fail_count++;
            end
         end
      end
   end

   // Stimulus
   initial begin
      cmd_type         c;
      traffic_mix_type mix;
      logic [QIDX_W-1:0] hot[4];
      int              random_sent;
      int              span;
      int              pct;
      int              add_pct;
      int              waited;

      for (int q = 0; q < NUM_QUEUES; q++) fill[q] = 0;
      for (int s = 0; s < 4; s++) status_tally[s] = 0;

      // directed: empty pops, extremes, urgent order, full queue, drain
      plan(OP_POP, 0,  16'hFFFF, 1'b1, 1'b1, ST_EMPTY,  16'h0000, 1'b0, 0);
      plan(OP_POP, 31, 16'h0000, 1'b0, 1'b1, ST_EMPTY,  16'h0000, 1'b0, 0);
      plan(OP_ADD, 31, 16'hFFFF, 1'b0, 1'b1, ST_ADDED,  16'h0000, 1'b0, 1);
      plan(OP_ADD, 31, 16'h0000, 1'b1, 1'b1, ST_ADDED,  16'h0000, 1'b0, 2);
      plan(OP_POP, 31, 16'hA5A5, 1'b0, 1'b1, ST_POPPED, 16'h0000, 1'b1, 1);
      plan(OP_POP, 31, 16'h5A5A, 1'b1, 1'b1, ST_POPPED, 16'hFFFF, 1'b0, 0);
      plan(OP_ADD, 0,  16'h0001, 1'b0, 1'b0, ST_ADDED,  16'h0000, 1'b0, 0);
      plan(OP_ADD, 0,  16'h8002, 1'b1, 1'b0, ST_ADDED,  16'h0000, 1'b0, 0);
      plan(OP_ADD, 0,  16'h0003, 1'b0, 1'b0, ST_ADDED,  16'h0000, 1'b0, 0);
      plan(OP_ADD, 0,  16'h4004, 1'b1, 1'b0, ST_ADDED,  16'h0000, 1'b0, 0);
      plan(OP_ADD, 0,  16'h0005, 1'b0, 1'b0, ST_ADDED,  16'h0000, 1'b0, 0);
      plan(OP_ADD, 0,  16'h2006, 1'b1, 1'b0, ST_ADDED,  16'h0000, 1'b0, 0);
      plan(OP_ADD, 0,  16'h0007, 1'b0, 1'b0, ST_ADDED,  16'h0000, 1'b0, 0);
      plan(OP_ADD, 0,  16'h1008, 1'b1, 1'b0, ST_ADDED,  16'h0000, 1'b0, 0);
      plan(OP_ADD, 0,  16'hFFFF, 1'b0, 1'b1, ST_FULL,   16'h0000, 1'b0, 8);
      plan(OP_ADD, 0,  16'h0000, 1'b1, 1'b1, ST_FULL,   16'h0000, 1'b0, 8);
      for (int k = 0; k < QUEUE_DEPTH; k++) begin
         plan(OP_POP, 0, 16'h0000, 1'b0, 1'b0, ST_EMPTY, 16'h0000, 1'b0, 0);
      end
      plan(OP_POP, 0,  16'hFFFF, 1'b1, 1'b1, ST_EMPTY,  16'h0000, 1'b0, 0);

      // hold reset, then release it
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_plan[k]) begin
         issue(directed_plan[k].cmd, directed_plan[k].typed, directed_plan[k].want);
      end

      // random phases clustered on a few hot queues
      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         mix  = traffic_mix_type'($urandom_range(0, 2));
         span = $urandom_range(40, 140);
         for (int k = 0; k < 4; k++) hot[k] = QIDX_W'($urandom_range(0, NUM_QUEUES - 1));
         case (mix)
            MIX_FILL:  add_pct = 75;
            MIX_DRAIN: add_pct = 25;
            default:   add_pct = 50;
         endcase
         repeat (span) begin
            pct       = $urandom_range(0, 99);
            c.op      = (pct < add_pct) ? OP_ADD : OP_POP;
            c.qidx    = ($urandom_range(0, 9) < 8) ? hot[$urandom_range(0, 3)]
                                                    : QIDX_W'($urandom);
            c.tag     = REQ_TAG_W'($urandom);
            c.urgent  = 1'($urandom);
            issue(c, 1'b0, '0);
            random_sent++;
         end
      end
      start <= 1'b0;

      // drain outstanding responses, then let the pipeline settle
      waited = 0;
      while (awaited_results.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (awaited_results.size() != 0) begin
         $error("%0d responses never arrived", awaited_results.size());
         fail_count++;
      end

      $display("covered %0d directed and %0d random items over %0d queues",
               directed_plan.size(), random_sent, NUM_QUEUES);
      $display("adds taken %0d, refused full %0d, pops with entry %0d, pops on empty %0d",
               status_tally[ST_ADDED], status_tally[ST_FULL], status_tally[ST_POPPED],
               status_tally[ST_EMPTY]);
      if (fail_count == 0) begin
         $display("per_class_queue_bank_urgent_front_core_test OK");
      end else begin
         $display("per_class_queue_bank_urgent_front_core_test NOT OK");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2000000;
      $display("per_class_queue_bank_urgent_front_core_test NOT OK");
      $finish;
   end

endmodule
